// ----- rtl/stack_bytecode_execute_unit_defines.svh -----
// Assertion helpers for the stack bytecode execute unit
`ifndef STACK_BYTECODE_EXECUTE_UNIT_DEFINES_SVH
`define STACK_BYTECODE_EXECUTE_UNIT_DEFINES_SVH

// assert that an antecedent implies a consequent on the next clock
`define SBX_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

// assert a condition at every clock outside reset
`define SBX_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("invariant failed");

`endif

// ----- rtl/sbx_pkg.sv -----
`timescale 1ns / 1ps
package sbx_pkg;
   localparam int STACK_DEPTH_DEF   = 64;
   localparam int NUM_REGISTERS_DEF = 16;
   localparam int PROGRAM_DEPTH_DEF = 65536;
   localparam int DATA_W = 64;
   localparam int CNT_W  = 17;

   typedef enum logic [4:0] {
      OP_NOP = 5'd0, OP_HALT = 5'd1, OP_PUSH = 5'd2, OP_POP = 5'd3,
      OP_ADD = 5'd4, OP_SUB = 5'd5, OP_MUL = 5'd6, OP_DIV = 5'd7,
      OP_MOD = 5'd8, OP_JMP = 5'd9, OP_CALL = 5'd10, OP_RET = 5'd11,
      OP_WHERE = 5'd12, OP_LIMIT = 5'd13, OP_OFFSET = 5'd14, OP_AND = 5'd15,
      OP_OR = 5'd16, OP_NOT = 5'd17, OP_EQ = 5'd18, OP_NE = 5'd19,
      OP_LT = 5'd20, OP_LE = 5'd21, OP_GT = 5'd22, OP_GE = 5'd23,
      OP_LOAD = 5'd24, OP_STORE = 5'd25
   } op_type;

   typedef enum logic [3:0] {
      ERR_NONE = 4'd0, ERR_OPERAND = 4'd1, ERR_TARGET = 4'd2, ERR_RET = 4'd3,
      ERR_DIVZERO = 4'd4, ERR_REG = 4'd5, ERR_UNDER = 4'd6, ERR_OVER = 4'd7,
      ERR_UNSUP = 4'd8
   } err_type;

   // ALU request/response between sequencer and shared unit
   typedef struct packed {
      logic       start;
      logic [4:0] op;
   } alu_ctl_type;

   typedef struct packed {
      logic done;
   } alu_sts_type;
endpackage

// ----- rtl/sbx_alu.sv -----
`timescale 1ns / 1ps
module sbx_alu (
   input  logic                 clock,
   input  logic                 reset,
   input  sbx_pkg::alu_ctl_type ctl,
   input  logic [63:0]          a,
   input  logic [63:0]          b,
   output sbx_pkg::alu_sts_type sts,
   output logic [63:0]          result
);
   import sbx_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_DONE} state_type;

   state_type   state_ff, state_in;
   logic [4:0]  op_ff, op_in;
   logic [63:0] acc_ff, acc_in;   // product or quotient
   logic [63:0] rem_ff, rem_in;
   logic [63:0] a_ff, a_in;       // multiplicand or dividend shifter
   logic [63:0] b_ff, b_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] res_ff, res_in;
   logic [64:0] trial;
   logic [63:0] mpart;

   // radix-4 multiply: 32 steps, one 64x2 partial product each
   assign mpart = (b_ff[0] ? a_ff : 64'd0) + (b_ff[1] ? {a_ff[62:0], 1'b0} : 64'd0);
   assign trial = {rem_ff, a_ff[63]} - {1'b0, b_ff};

   always_comb begin
      state_in = state_ff; op_in = op_ff; acc_in = acc_ff; rem_in = rem_ff;
      a_in = a_ff; b_in = b_ff; cnt_in = cnt_ff; res_in = res_ff;
      case (state_ff)
         S_IDLE: if (ctl.start) begin
            op_in = ctl.op; a_in = a; b_in = b; acc_in = '0; rem_in = '0; cnt_in = '0;
            case (ctl.op)
               OP_ADD: begin res_in = a + b; state_in = S_DONE; end
               OP_SUB: begin res_in = a - b; state_in = S_DONE; end
               OP_MUL: state_in = S_MUL;
               OP_DIV, OP_MOD: state_in = S_DIV;
               OP_AND: begin res_in = {63'd0, (a != 0) && (b != 0)}; state_in = S_DONE; end
               OP_OR:  begin res_in = {63'd0, (a != 0) || (b != 0)}; state_in = S_DONE; end
               OP_EQ:  begin res_in = {63'd0, a == b}; state_in = S_DONE; end
               OP_NE:  begin res_in = {63'd0, a != b}; state_in = S_DONE; end
               OP_LT:  begin res_in = {63'd0, a < b}; state_in = S_DONE; end
               OP_LE:  begin res_in = {63'd0, a <= b}; state_in = S_DONE; end
               OP_GT:  begin res_in = {63'd0, a > b}; state_in = S_DONE; end
               default: begin res_in = {63'd0, a >= b}; state_in = S_DONE; end
            endcase
         end
         S_MUL: begin
            acc_in = acc_ff + mpart;
            a_in = {a_ff[61:0], 2'b00};
            b_in = {2'b00, b_ff[63:2]};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd31) begin res_in = acc_ff + mpart; state_in = S_DONE; end
         end
         S_DIV: begin
            // restoring division, one quotient bit per cycle
            a_in = {a_ff[62:0], 1'b0};
            if (!trial[64]) begin
               rem_in = trial[63:0]; acc_in = {acc_ff[62:0], 1'b1};
            end else begin
               rem_in = {rem_ff[62:0], a_ff[63]}; acc_in = {acc_ff[62:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               res_in = (op_ff == OP_MOD) ? rem_in : acc_in;
               state_in = S_DONE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff <= op_in; acc_ff <= acc_in; rem_ff <= rem_in; a_ff <= a_in;
      b_ff <= b_in; cnt_ff <= cnt_in; res_ff <= res_in;
   end

   assign sts.done = (state_ff == S_DONE);
   assign result   = res_ff;
endmodule

// ----- rtl/stack_bytecode_execute_unit.sv -----
`timescale 1ns / 1ps
// Stack bytecode execute unit.
// req channel: one instruction per request. req_tdata holds operation [4:0],
// has_immediate [5], immediate [69:6]. rsp channel: one response per request,
// rsp_tdata holds next_counter, finished, error_code, top_value, stack_count,
// where_flag from bit 0 up. csr_wr_en/csr_wr_data set program_length.
// One request at a time: req_tready is high only while the unit is idle.
// Most ops step through accept, stack read and update; arithmetic and
// compares also go through the shared ALU: multiply takes two bits per
// step, divide and modulo one quotient bit per step. The stack and
// register file are read once per cycle from their single port.
// The next request is taken in the cycle after the response is
// accepted, so no new request is taken while one is in flight.
// Reset clears the stack pointer, counter, where bit and register file
// (valid bits per register) and sets program_length to 65536.
// While rsp_tready is low the response is held in the output register and
// no new request is taken.
`include "stack_bytecode_execute_unit_defines.svh"
module stack_bytecode_execute_unit #(
   parameter int STACK_DEPTH   = sbx_pkg::STACK_DEPTH_DEF,
   parameter int NUM_REGISTERS = sbx_pkg::NUM_REGISTERS_DEF,
   parameter int PROGRAM_DEPTH = sbx_pkg::PROGRAM_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [71:0]  req_tdata,   // operation, has_immediate, immediate, pad
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,   // next_counter, finished, error_code,
                                     // top_value, stack_count, where_flag, pad
   input  logic         csr_wr_en,
   input  logic [16:0]  csr_wr_data  // program_length
);
   import sbx_pkg::*;

   localparam int SP_W  = $clog2(STACK_DEPTH + 1);
   localparam int SA_W  = $clog2(STACK_DEPTH);
   localparam int RA_W  = (NUM_REGISTERS > 1) ? $clog2(NUM_REGISTERS) : 1;
   localparam logic [16:0] PDEPTH = 17'(PROGRAM_DEPTH);
   localparam logic [SP_W-1:0] SFULL = SP_W'(STACK_DEPTH);

   typedef enum logic [2:0] {S_IDLE, S_READ, S_EXEC, S_ALU, S_RESP} state_type;

   state_type        state_ff;
   logic [4:0]       op_ff;
   logic             hasi_ff;
   logic [63:0]      imm_ff;
   logic [SP_W-1:0]  sp_ff;
   logic [16:0]      pc_ff;
   logic             where_ff;
   logic [16:0]      plen_ff;
   logic [63:0]      top_ff;        // cached top of stack
   logic [63:0]      second_ff;     // entry below top, read in S_READ
   logic [63:0]      regrd_ff;
   logic [3:0]       err_ff;
   logic             fin_ff;

   logic [63:0] stack_mem [STACK_DEPTH];
   logic [63:0] reg_mem   [NUM_REGISTERS];
   logic [NUM_REGISTERS-1:0] reg_valid_ff;

   logic [16:0] plen;
   logic        st_we;
   logic [SA_W-1:0] st_waddr;
   logic [63:0] st_wdata;
   logic        rf_we;
   alu_ctl_type alu_ctl;
   alu_sts_type alu_sts;
   logic [63:0] alu_res;
   logic        imm_reg_ok;
   logic [RA_W-1:0] ridx;
   logic        imm_tgt_ok;

   assign plen = (plen_ff > PDEPTH) ? PDEPTH : plen_ff;
   assign imm_reg_ok = !imm_ff[63] && (imm_ff < 64'(NUM_REGISTERS));
   assign imm_tgt_ok = !imm_ff[63] && (imm_ff < {47'd0, plen});
   assign ridx = RA_W'(imm_ff);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RESP);

   sbx_alu u_alu (
      .clock(clock), .reset(reset), .ctl(alu_ctl),
      .a(second_ff), .b(top_ff), .sts(alu_sts), .result(alu_res)
   );

   always_ff @(posedge clock) begin
      if (st_we) stack_mem[st_waddr] <= st_wdata;
      if (rf_we) reg_mem[ridx] <= top_ff;
      second_ff <= stack_mem[SA_W'(sp_ff - SP_W'(2))];
      regrd_ff  <= reg_valid_ff[ridx] ? reg_mem[ridx] : 64'd0;
   end

   always_comb begin
      st_we = 1'b0; st_waddr = SA_W'(sp_ff); st_wdata = imm_ff; rf_we = 1'b0;
      alu_ctl.start = 1'b0; alu_ctl.op = op_ff;
      if (state_ff == S_EXEC && pc_ff < plen) begin
         case (op_ff)
            OP_PUSH, OP_LIMIT, OP_OFFSET:
               st_we = hasi_ff && sp_ff < SFULL;
            OP_CALL: begin
               st_we = hasi_ff && imm_tgt_ok && sp_ff < SFULL;
               st_wdata = {47'd0, pc_ff} + 64'd1;
            end
            OP_LOAD: begin
               st_we = hasi_ff && imm_reg_ok && sp_ff < SFULL;
               st_wdata = regrd_ff;
            end
            OP_STORE: rf_we = hasi_ff && imm_reg_ok && sp_ff != '0;
            OP_NOT: begin
               st_we = sp_ff != '0; st_waddr = SA_W'(sp_ff - SP_W'(1));
               st_wdata = {63'd0, top_ff == 64'd0};
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_OR,
            OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE:
               alu_ctl.start = (sp_ff >= SP_W'(2)) &&
                  !((op_ff == OP_DIV || op_ff == OP_MOD) && top_ff == 64'd0);
            default: ;
         endcase
      end else if (state_ff == S_ALU && alu_sts.done) begin
         st_we = 1'b1; st_waddr = SA_W'(sp_ff - SP_W'(2)); st_wdata = alu_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; sp_ff <= '0; pc_ff <= '0; where_ff <= 1'b0;
         plen_ff <= 17'h10000; reg_valid_ff <= '0; top_ff <= '0;
      end else begin
         if (csr_wr_en) plen_ff <= csr_wr_data;
         if (rf_we) reg_valid_ff[ridx] <= 1'b1;
         case (state_ff)
            S_IDLE: if (req_tvalid) begin
               op_ff <= req_tdata[4:0]; hasi_ff <= req_tdata[5];
               imm_ff <= req_tdata[69:6]; state_ff <= S_READ;
            end
            S_READ: state_ff <= S_EXEC;
            S_EXEC: begin
               err_ff <= ERR_NONE; fin_ff <= 1'b0; state_ff <= S_RESP;
               if (pc_ff >= plen) begin
                  fin_ff <= 1'b1;
               end else begin
                  case (op_ff)
                     OP_NOP: pc_ff <= pc_ff + 17'd1;
                     OP_HALT: fin_ff <= 1'b1;
                     OP_PUSH, OP_LIMIT, OP_OFFSET, OP_LOAD:
                        if (!hasi_ff) err_ff <= ERR_OPERAND;
                        else if (op_ff == OP_LOAD && !imm_reg_ok) err_ff <= ERR_REG;
                        else if (sp_ff >= SFULL) err_ff <= ERR_OVER;
                        else begin
                           top_ff <= st_wdata; sp_ff <= sp_ff + SP_W'(1);
                           pc_ff <= pc_ff + 17'd1;
                        end
                     OP_POP: begin
                        if (sp_ff != '0) begin
                           sp_ff <= sp_ff - SP_W'(1); top_ff <= second_ff;
                        end
                        pc_ff <= pc_ff + 17'd1;
                     end
                     OP_JMP, OP_CALL:
                        if (!hasi_ff) err_ff <= ERR_OPERAND;
                        else if (!imm_tgt_ok) err_ff <= ERR_TARGET;
                        else if (op_ff == OP_CALL && sp_ff >= SFULL) err_ff <= ERR_OVER;
                        else begin
                           if (op_ff == OP_CALL) begin
                              top_ff <= st_wdata; sp_ff <= sp_ff + SP_W'(1);
                           end
                           pc_ff <= imm_ff[16:0];
                        end
                     OP_RET:
                        if (sp_ff == '0) err_ff <= ERR_RET;
                        else begin
                           sp_ff <= sp_ff - SP_W'(1); top_ff <= second_ff;
                           pc_ff <= (top_ff > {47'd0, plen}) ? plen : top_ff[16:0];
                        end
                     OP_WHERE: begin where_ff <= 1'b1; pc_ff <= pc_ff + 17'd1; end
                     OP_NOT:
                        if (sp_ff == '0) err_ff <= ERR_UNDER;
                        else begin top_ff <= st_wdata; pc_ff <= pc_ff + 17'd1; end
                     OP_STORE:
                        if (!hasi_ff) err_ff <= ERR_OPERAND;
                        else if (!imm_reg_ok) err_ff <= ERR_REG;
                        else if (sp_ff == '0) err_ff <= ERR_UNDER;
                        else begin
                           sp_ff <= sp_ff - SP_W'(1); top_ff <= second_ff;
                           pc_ff <= pc_ff + 17'd1;
                        end
                     OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_OR,
                     OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE:
                        if (sp_ff < SP_W'(2)) err_ff <= ERR_UNDER;
                        else if (!alu_ctl.start) err_ff <= ERR_DIVZERO;
                        else state_ff <= S_ALU;
                     default: err_ff <= ERR_UNSUP;
                  endcase
               end
            end
            S_ALU: if (alu_sts.done) begin
               top_ff <= alu_res; sp_ff <= sp_ff - SP_W'(1);
               pc_ff <= pc_ff + 17'd1; state_ff <= S_RESP;
            end
            S_RESP: if (rsp_tready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   logic [16:0] nc;
   logic        fin;
   assign nc  = (pc_ff > plen) ? plen : pc_ff;
   assign fin = fin_ff || (err_ff != ERR_NONE) || (pc_ff >= plen);
   assign rsp_tdata = {2'd0, where_ff, 7'(sp_ff), (sp_ff != '0) ? top_ff : 64'd0,
                       err_ff, fin, nc};

   `SBX_ASSERT_NEXT(a_alu_only_from_exec, clock, reset, alu_ctl.start, state_ff == S_ALU)
   `SBX_ASSERT_ALWAYS(a_sp_bound, clock, reset, sp_ff <= SFULL)
   `SBX_ASSERT_ALWAYS(a_err_range, clock, reset, !rsp_tvalid || err_ff <= ERR_UNSUP)
endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
   import sbx_pkg::*;

   localparam int DEPTH = 64;
   localparam int NREGS = 16;
   localparam logic [4:0] OP_UNSUP_LO = 5'd26;
   localparam logic [4:0] OP_UNSUP_HI = 5'd31;

   typedef struct packed {
      logic [4:0]  op;
      logic        has_imm;
      logic [63:0] imm;
   } instr_type;

   // packed from the top bit down: where_flag is highest, counter lowest
   typedef struct packed {
      logic        where_flag;
      logic [6:0]  count;
      logic [63:0] top;
      logic [3:0]  err;
      logic        finished;
      logic [16:0] counter;
   } status_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [71:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [95:0] rsp_tdata;
   logic csr_wr_en = 0;
   logic [16:0] csr_wr_data = '0;

   stack_bytecode_execute_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // machine state mirrored for prediction
   logic [63:0] m_stack [DEPTH];
   int          m_sp;
   logic [63:0] m_regs [NREGS];
   int          m_pc;
   logic        m_where;
   int          m_plen;

   instr_type  pending_instrs[$];
   status_type expected_status[$];
   int errors = 0;
   int checked = 0;
   int send_idle = 14;
   int recv_idle = 58;
   int err_seen[9];

   function automatic logic [63:0] alu_result(logic [4:0] op, logic [63:0] a, logic [63:0] b);
      case (op)
         OP_ADD: return a + b;
         OP_SUB: return a - b;
         OP_MUL: return a * b;
         OP_DIV: return a / b;
         OP_MOD: return a % b;
         OP_AND: return 64'(a != 0 && b != 0);
         OP_OR:  return 64'(a != 0 || b != 0);
         OP_EQ:  return 64'(a == b);
         OP_NE:  return 64'(a != b);
         OP_LT:  return 64'(a < b);
         OP_LE:  return 64'(a <= b);
         OP_GT:  return 64'(a > b);
         default: return 64'(a >= b);
      endcase
   endfunction

   function automatic status_type execute_instr(instr_type it);
      status_type s;
      err_type e;
      logic fin;
      logic [63:0] a, b, t;
      e = ERR_NONE;
      fin = 1'b0;
      if (m_pc >= m_plen) begin
         fin = 1'b1;
      end else begin
         case (it.op)
            OP_NOP: m_pc++;
            OP_HALT: fin = 1'b1;
            OP_PUSH, OP_LIMIT, OP_OFFSET: begin
               if (!it.has_imm) e = ERR_OPERAND;
               else if (m_sp >= DEPTH) e = ERR_OVER;
               else begin
                  m_stack[m_sp] = it.imm; m_sp++; m_pc++;
               end
            end
            OP_POP: begin
               if (m_sp > 0) m_sp--;
               m_pc++;
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_OR,
            OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE: begin
               if (m_sp < 2) e = ERR_UNDER;
               else begin
                  a = m_stack[m_sp-2];
                  b = m_stack[m_sp-1];
                  if ((it.op == OP_DIV || it.op == OP_MOD) && b == 0) e = ERR_DIVZERO;
                  else begin
                     m_stack[m_sp-2] = alu_result(it.op, a, b);
                     m_sp--; m_pc++;
                  end
               end
            end
            OP_JMP, OP_CALL: begin
               if (!it.has_imm) e = ERR_OPERAND;
               else if (it.imm[63] || it.imm >= 64'(m_plen)) e = ERR_TARGET;
               else if (it.op == OP_CALL && m_sp >= DEPTH) e = ERR_OVER;
               else begin
                  if (it.op == OP_CALL) begin
                     m_stack[m_sp] = 64'(m_pc + 1); m_sp++;
                  end
                  m_pc = int'(it.imm[16:0]);
               end
            end
            OP_RET: begin
               if (m_sp == 0) e = ERR_RET;
               else begin
                  m_sp--;
                  t = m_stack[m_sp];
                  m_pc = (t > 64'(m_plen)) ? m_plen : int'(t[16:0]);
               end
            end
            OP_WHERE: begin
               m_where = 1'b1; m_pc++;
            end
            OP_NOT: begin
               if (m_sp < 1) e = ERR_UNDER;
               else begin
                  m_stack[m_sp-1] = 64'(m_stack[m_sp-1] == 0); m_pc++;
               end
            end
            OP_LOAD, OP_STORE: begin
               if (!it.has_imm) e = ERR_OPERAND;
               else if (it.imm[63] || it.imm >= 64'(NREGS)) e = ERR_REG;
               else if (it.op == OP_LOAD) begin
                  if (m_sp >= DEPTH) e = ERR_OVER;
                  else begin
                     m_stack[m_sp] = m_regs[it.imm[3:0]]; m_sp++; m_pc++;
                  end
               end else begin
                  if (m_sp < 1) e = ERR_UNDER;
                  else begin
                     m_sp--; m_regs[it.imm[3:0]] = m_stack[m_sp]; m_pc++;
                  end
               end
            end
            default: e = ERR_UNSUP;
         endcase
         if (e != ERR_NONE || m_pc >= m_plen) fin = 1'b1;
      end
      s.counter = 17'((m_pc > m_plen) ? m_plen : m_pc);
      s.finished = fin;
      s.err = e;
      s.top = (m_sp > 0) ? m_stack[m_sp-1] : 64'd0;
      s.count = 7'(m_sp);
      s.where_flag = m_where;
      return s;
   endfunction

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h (response %0d)", field, got, want, checked);
      errors++;
   endtask

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            // request taken at the last rising edge
         end
      end
   end

   instr_type  cur;
   status_type predicted;
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         predicted = execute_instr(cur);
         expected_status = {expected_status, predicted};
         void'(pending_instrs.pop_front());
      end
   end

   // track whether the presented request is still waiting, so it is not withdrawn
   logic req_tready_sampled = 0;
   always @(posedge clock) req_tready_sampled <= req_tvalid ? req_tready : 1'b0;

   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || !pending_instrs.size()) begin
            // nothing held
         end
         if (pending_instrs.size() > 0 && $urandom_range(99) >= send_idle) begin
            cur <= pending_instrs[0];
            req_tdata <= {2'b0, pending_instrs[0].imm, pending_instrs[0].has_imm,
                          pending_instrs[0].op};
            req_tvalid <= 1;
         end else if (!(req_tvalid && !req_tready_sampled)) begin
            req_tvalid <= 0;
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // monitor
   status_type got, want;
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[93:0];
         if (expected_status.size() == 0) begin
            report_mismatch("unexpected response", 64'(got.counter), 64'd0);
         end else begin
            want = expected_status.pop_front();
            err_seen[want.err]++;
            if (got.counter !== want.counter) report_mismatch("next_counter", got.counter, want.counter);
            if (got.finished !== want.finished) report_mismatch("finished", got.finished, want.finished);
            if (got.err !== want.err) report_mismatch("error_code", got.err, want.err);
            if (got.top !== want.top) report_mismatch("top_value", got.top, want.top);
            if (got.count !== want.count) report_mismatch("stack_count", got.count, want.count);
            if (got.where_flag !== want.where_flag)
               report_mismatch("where_flag", got.where_flag, want.where_flag);
         end
         checked++;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic instr_type make_instr(logic [4:0] op, logic has_imm, logic [63:0] imm);
      instr_type it;
      it.op = op; it.has_imm = has_imm; it.imm = imm;
      return it;
   endfunction

   task automatic add_instr(logic [4:0] op, logic has_imm, logic [63:0] imm);
      pending_instrs = {pending_instrs, make_instr(op, has_imm, imm)};
   endtask

   task automatic drain();
      while (pending_instrs.size() > 0 || expected_status.size() > 0 || req_tvalid)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_length(int len);
      @(negedge clock);
      csr_wr_en <= 1;
      csr_wr_data <= 17'(len);
      @(negedge clock);
      csr_wr_en <= 0;
      m_plen = (len > 65536) ? 65536 : len;
   endtask

   // random traffic with a mix of in-range and out-of-range immediates
   task automatic queue_random(int n, int plen);
      logic [4:0] op;
      logic [63:0] imm;
      int sel;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(99);
         op = 5'($urandom_range(25));
         if (sel < 3) op = 5'($urandom_range(31));
         case ($urandom_range(5))
            0: imm = rand64();
            1: imm = 64'($urandom_range(NREGS + 1));
            2: imm = 64'($urandom_range(plen));
            3: imm = {1'b1, 63'($urandom())};
            4: imm = 64'($urandom_range(3));
            default: imm = 64'($urandom_range(plen > 1 ? plen - 1 : 0));
         endcase
         if (op == OP_DIV || op == OP_MOD) begin
            add_instr(OP_PUSH, 1'b1, rand64());
            add_instr(OP_PUSH, 1'b1, (sel < 10) ? 64'd0 : rand64());
         end
         // halt and jumps keep the counter in range so most items execute
         add_instr(op, sel < 95, imm);
      end
   endtask

   initial begin
      int targets[5] = '{65536, 1, 100000, 40, 200};
      for (int i = 0; i < NREGS; i++) m_regs[i] = 0;
      m_sp = 0; m_pc = 0; m_where = 0; m_plen = 65536;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: extremes and special cases
      add_instr(OP_POP, 1'b0, 64'd0);
      add_instr(OP_RET, 1'b0, 64'd0);
      add_instr(OP_ADD, 1'b0, 64'd0);
      add_instr(OP_NOT, 1'b0, 64'd0);
      add_instr(OP_STORE, 1'b1, 64'd3);
      add_instr(OP_PUSH, 1'b0, 64'd0);
      add_instr(OP_PUSH, 1'b1, '1);
      add_instr(OP_PUSH, 1'b1, 64'h8000_0000_0000_0000);
      add_instr(OP_MUL, 1'b1, 64'd5);
      add_instr(OP_LIMIT, 1'b1, 64'd0);
      add_instr(OP_DIV, 1'b0, 64'd0);
      add_instr(OP_OFFSET, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF);
      add_instr(OP_STORE, 1'b1, 64'd15);
      add_instr(OP_LOAD, 1'b1, 64'd16);
      add_instr(OP_LOAD, 1'b1, '1);
      add_instr(OP_LOAD, 1'b1, 64'd15);
      add_instr(OP_JMP, 1'b1, 64'd65536);
      add_instr(OP_JMP, 1'b1, '1);
      add_instr(OP_CALL, 1'b1, 64'd65535);
      add_instr(OP_RET, 1'b0, 64'd0);
      add_instr(OP_WHERE, 1'b0, 64'd0);
      add_instr(OP_HALT, 1'b0, 64'd0);
      add_instr(OP_UNSUP_HI, 1'b1, 64'd0);
      add_instr(OP_UNSUP_LO, 1'b0, 64'd0);
      drain();

      // fill to overflow
      for (int i = 0; i < 66; i++) add_instr(OP_PUSH, 1'b1, rand64());
      add_instr(OP_CALL, 1'b1, 64'd2);
      add_instr(OP_LOAD, 1'b1, 64'd0);
      for (int i = 0; i < 70; i++) add_instr(OP_POP, 1'b1, rand64());
      drain();

      for (int ph = 0; ph < 5; ph++) begin
         if (ph == 2) begin send_idle = 58; recv_idle = 14; end
         if (ph == 4) begin send_idle = 0; recv_idle = 0; end
         write_length(targets[ph]);
         // restart counter inside the program
         if (m_pc >= m_plen) begin
            add_instr(OP_NOP, 1'b0, 64'd0);
         end
         add_instr(OP_PUSH, 1'b1, 64'd0);
         add_instr(OP_RET, 1'b0, 64'd0);
         queue_random(ph == 1 ? 40 : 170, m_plen);
         drain();
      end
      $display("checked %0d responses over 5 program lengths (1 to 65536 and beyond)", checked);
      $display("errors hit: operand %0d target %0d ret %0d div %0d reg %0d under %0d over %0d unsup %0d",
               err_seen[1], err_seen[2], err_seen[3], err_seen[4], err_seen[5],
               err_seen[6], err_seen[7], err_seen[8]);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #8000000;
      $display("FAIL");
      $finish;
   end
endmodule
